// ----- rtl/core/utf8_to_cp1251_transcoder_macros.svh -----
// assertion helpers shared by the transcoder
`ifndef UTF8_TO_CP1251_TRANSCODER_MACROS_SVH
`define UTF8_TO_CP1251_TRANSCODER_MACROS_SVH

// same-cycle implication, quiet during reset
`define U2C_ASSERT_IMPL(label, cond, expr) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (expr)) \
        else $error("transcoder check failed");

// next-cycle implication, also checked through reset
`define U2C_ASSERT_NEXT(label, cond, expr) \
    label: assert property (@(posedge i_clk) (cond) |=> (expr)) \
        else $error("transcoder check failed");

`endif

// ----- rtl/core/u2c_pkg.sv -----
package u2c_pkg;

    localparam int COUNT_BITS_DEF  = 24;
    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int LEN_W           = 24;
    localparam int CP_W            = 21;

    // configuration register indexes
    localparam logic CFG_MAX_LEN = 1'b0;
    localparam logic CFG_ABORT   = 1'b1;

    localparam logic [7:0] CH_QMARK = 8'h3f;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_SEMI  = 8'h3b;

    // marker digits
    localparam logic [2:0] MK_ASCII_IN_SEQ = 3'd1;
    localparam logic [2:0] MK_STRAY_CONT   = 3'd2;
    localparam logic [2:0] MK_OVERLONG     = 3'd3;
    localparam logic [2:0] MK_LEAD_IN_SEQ  = 3'd4;
    localparam logic [2:0] MK_BAD_LEAD     = 3'd5;
    localparam logic [2:0] MK_OPEN_AT_END  = 3'd6;

    typedef enum logic [2:0] {
        MN_NONE, MN_BYTE, MN_ESC, MN_MARK, MN_ERR
    } t_main;

    typedef enum logic [1:0] {
        SG_PRE, SG_MAIN, SG_END, SG_DONE
    } t_seg;

    // work for one input byte, handed from front to back
    typedef struct packed {
        logic            pre;
        logic [2:0]      pre_dig;
        t_main           main;
        logic [7:0]      data;
        logic [CP_W-1:0] cp;
        logic [2:0]      ndig;
        logic [2:0]      mark_dig;
        logic            end_mark;
        logic            end_err;
        logic            done;
        logic            done_err;
    } t_job;

    typedef struct packed {
        logic [LEN_W-1:0] max_len;
        logic             abort;
    } t_cfg;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    localparam logic [7:0] PAGE04_LO [16] = '{
        8'h00, 8'ha8, 8'h80, 8'h81, 8'haa, 8'hbd, 8'hb2, 8'haf,
        8'ha3, 8'h8a, 8'h8c, 8'h8e, 8'h8d, 8'h00, 8'ha1, 8'h8f};
    localparam logic [7:0] PAGE04_HI [16] = '{
        8'h00, 8'hb8, 8'h90, 8'h83, 8'hba, 8'hbe, 8'hb3, 8'hbf,
        8'hbc, 8'h9a, 8'h9c, 8'h9e, 8'h9d, 8'h00, 8'ha2, 8'h9f};
    localparam logic [7:0] PAGE20_LO [64] = '{
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h96, 8'h97, 8'h00, 8'h00, 8'h00,
        8'h91, 8'h92, 8'h82, 8'h00, 8'h93, 8'h94, 8'h84, 8'h00,
        8'h86, 8'h87, 8'h95, 8'h00, 8'h00, 8'h00, 8'h85, 8'h00,
        8'h00, 8'h00, 8'h00, 8'hda, 8'hda, 8'h00, 8'hda, 8'h00,
        8'h89, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h8b, 8'h9b, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};

    // code point to cp1251 byte, zero when unmapped
    function automatic logic [7:0] map_code(input logic [CP_W-1:0] cp);
        logic [7:0] lo;
        logic [7:0] res;
        lo  = cp[7:0];
        res = 8'h00;
        unique case (cp[CP_W-1:8])
            13'h000: begin
                if (lo == 8'ha0 || lo == 8'ha4 || lo == 8'ha6 || lo == 8'ha7 ||
                    lo == 8'ha9 || lo == 8'hab || lo == 8'hac || lo == 8'had ||
                    lo == 8'hae || lo == 8'hb0 || lo == 8'hb1 || lo == 8'hb5 ||
                    lo == 8'hb6 || lo == 8'hb7 || lo == 8'hbb) begin
                    res = lo;
                end
            end
            13'h004: begin
                if (lo < 8'h10) begin
                    res = PAGE04_LO[lo[3:0]];
                end else if (lo < 8'h50) begin
                    res = lo + 8'hb0;
                end else if (lo < 8'h60) begin
                    res = PAGE04_HI[lo[3:0]];
                end else if (lo == 8'h90) begin
                    res = 8'ha5;
                end else if (lo == 8'h91) begin
                    res = 8'hb4;
                end
            end
            13'h020: begin
                if (lo < 8'h40) begin
                    res = PAGE20_LO[lo[5:0]];
                end else if (lo == 8'hac) begin
                    res = 8'h88;
                end
            end
            13'h021: begin
                if (lo == 8'h16) begin
                    res = 8'hb9;
                end else if (lo == 8'h22) begin
                    res = 8'h99;
                end
            end
            13'h0ff: begin
                if (lo == 8'hfd) begin
                    res = 8'h20;
                end
            end
            default: res = 8'h00;
        endcase
        return res;
    endfunction

    // decimal digit count of a code point
    function automatic logic [2:0] num_digits(input logic [CP_W-1:0] cp);
        logic [2:0] n;
        priority if (cp >= 21'd1000000) n = 3'd7;
        else if (cp >= 21'd100000)      n = 3'd6;
        else if (cp >= 21'd10000)       n = 3'd5;
        else if (cp >= 21'd1000)        n = 3'd4;
        else if (cp >= 21'd100)         n = 3'd3;
        else if (cp >= 21'd10)          n = 3'd2;
        else                            n = 3'd1;
        return n;
    endfunction

    function automatic logic [CP_W-1:0] pow10(input logic [2:0] p);
        logic [CP_W-1:0] v;
        unique case (p)
            3'd0: v = 21'd1;
            3'd1: v = 21'd10;
            3'd2: v = 21'd100;
            3'd3: v = 21'd1000;
            3'd4: v = 21'd10000;
            3'd5: v = 21'd100000;
            3'd6: v = 21'd1000000;
            default: v = 21'd1;
        endcase
        return v;
    endfunction

    // output bytes a job produces
    function automatic logic [4:0] job_bytes(input t_job j);
        logic [4:0] n;
        n = j.pre ? 5'd3 : 5'd0;
        unique case (j.main)
            MN_BYTE: n = n + 5'd1;
            MN_ESC:  n = n + 5'd3 + {2'b00, j.ndig};
            MN_MARK: n = n + 5'd3;
            default: n = n;
        endcase
        if (j.end_mark) begin
            n = n + 5'd3;
        end
        return n;
    endfunction

endpackage

// ----- rtl/core/utf8_to_cp1251_transcoder.sv -----
// UTF-8 to Windows-1251 transcoder.
// Input channel: i_valid / o_ready carry one UTF-8 byte per item (i_in_byte)
// with i_text_end on the last byte of a text. Output channel: o_valid /
// i_ready carry result items (o_out_byte, o_has_byte, o_error_abort,
// o_run_last, o_done_res); o_run_last closes the results of one input byte.
// Configuration: i_cfg_we writes i_cfg_data into register i_cfg_idx
// (0: output byte limit, 1: abort mode); the user must write only while
// the block is idle, which the block itself does not enforce. The front
// decoder takes one byte per cycle while the queue has room and posts a
// job to a queue of QUEUE_DEPTH entries; the back sequencer emits one item
// per cycle while the receiver is ready. Throughput: one byte per cycle
// while each byte yields one item and the receiver is ready; a byte
// yielding k items holds the back end until all k are out (up to 11 for a
// seven-digit escape &#N; followed by the done item), and the front keeps
// accepting until the queue fills. A stalled receiver holds the output
// register; the queue then fills and o_ready drops. Reset empties the
// queue, clears the decoder state and both configuration registers.
module utf8_to_cp1251_transcoder
    import u2c_pkg::*;
#(
    parameter int COUNT_BITS  = COUNT_BITS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [7:0]       i_in_byte,
    input  logic             i_text_end,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [7:0]       o_out_byte,
    output logic             o_has_byte,
    output logic             o_error_abort,
    output logic             o_run_last,
    output logic             o_done_res,
    input  logic             i_cfg_we,
    input  logic             i_cfg_idx,
    input  logic [LEN_W-1:0] i_cfg_data
);

`include "utf8_to_cp1251_transcoder_macros.svh"

    t_cfg    r_cfg;
    t_job    push_job, head;
    logic    q_push, q_pop;
    t_q_stat q_stat;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MAX_LEN: r_cfg.max_len <= i_cfg_data;
                CFG_ABORT:   r_cfg.abort   <= i_cfg_data[0];
                default:     r_cfg         <= r_cfg;
            endcase
        end
    end

    u2c_front #(.COUNT_BITS(COUNT_BITS)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_in_byte  (i_in_byte),
        .i_text_end (i_text_end),
        .i_cfg      (r_cfg),
        .i_q_stat   (q_stat),
        .o_ready    (o_ready),
        .o_push     (q_push),
        .o_job      (push_job)
    );

    u2c_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (push_job),
        .i_pop   (q_pop),
        .o_head  (head),
        .o_stat  (q_stat)
    );

    u2c_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (head),
        .i_q_stat      (q_stat),
        .i_ready       (i_ready),
        .o_pop         (q_pop),
        .o_valid       (o_valid),
        .o_out_byte    (o_out_byte),
        .o_has_byte    (o_has_byte),
        .o_error_abort (o_error_abort),
        .o_run_last    (o_run_last),
        .o_done_res    (o_done_res)
    );

    // checks
    `U2C_ASSERT_IMPL(a_no_overflow, q_push, !q_stat.full)
    `U2C_ASSERT_IMPL(a_no_underflow, q_pop, !q_stat.empty)
    `U2C_ASSERT_IMPL(a_done_closes, o_valid && o_done_res, o_run_last && !o_has_byte)
    `U2C_ASSERT_NEXT(a_reset_idle, !i_rst_n, !o_valid)

endmodule

// ----- rtl/core/u2c_front.sv -----
module u2c_front
    import u2c_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_in_byte,
    input  logic       i_text_end,
    input  t_cfg       i_cfg,
    input  t_q_stat    i_q_stat,
    output logic       o_ready,
    output logic       o_push,
    output t_job       o_job
);

    localparam int CMP_W = 33;
    localparam logic [COUNT_BITS-1:0] CAP = {COUNT_BITS{1'b1}};

    logic [1:0]            r_pend, n_pend;
    logic [CP_W-1:0]       r_part, n_part;
    logic [COUNT_BITS-1:0] r_count, n_count;
    logic                  r_abt, n_abt;
    logic                  r_lim, n_lim;
    t_job                  job;
    logic                  accept;
    logic [COUNT_BITS:0]   sum;
    logic [7:0]            mapped;
    logic [CP_W-1:0]       acc;

    assign o_ready = !i_q_stat.full;
    assign accept  = i_valid && o_ready;

    assign acc    = {r_part[CP_W-7:0], i_in_byte[5:0]};
    assign mapped = map_code(acc);

    // classify one byte into a job and the next decoder state
    always_comb begin
        job     = '0;
        job.main = MN_NONE;
        n_pend  = r_pend;
        n_part  = r_part;
        n_abt   = r_abt;
        n_lim   = r_lim;
        n_count = r_count;
        sum     = '0;
        if (!r_abt && !r_lim) begin
            if (i_cfg.max_len != '0 &&
                CMP_W'(r_count) >= CMP_W'(i_cfg.max_len)) begin
                n_lim = 1'b1;
            end else if (i_in_byte < 8'h80) begin
                if (r_pend != 2'd0 && i_cfg.abort) begin
                    job.main = MN_ERR;
                    n_abt    = 1'b1;
                end else begin
                    job.pre     = (r_pend != 2'd0);
                    job.pre_dig = MK_ASCII_IN_SEQ;
                    job.main    = MN_BYTE;
                    job.data    = i_in_byte;
                    n_pend      = 2'd0;
                end
            end else if (i_in_byte[7:6] == 2'b10) begin
                if (r_pend == 2'd0) begin
                    if (i_cfg.abort) begin
                        job.main = MN_ERR;
                        n_abt    = 1'b1;
                    end else begin
                        job.main     = MN_MARK;
                        job.mark_dig = MK_STRAY_CONT;
                    end
                end else begin
                    n_part = acc;
                    n_pend = r_pend - 2'd1;
                    if (r_pend == 2'd1) begin
                        if (acc < 21'h80) begin
                            if (i_cfg.abort) begin
                                job.main = MN_ERR;
                                n_abt    = 1'b1;
                            end else begin
                                job.main     = MN_MARK;
                                job.mark_dig = MK_OVERLONG;
                            end
                        end else if (mapped != 8'h00) begin
                            job.main = MN_BYTE;
                            job.data = mapped;
                        end else begin
                            job.main = MN_ESC;
                            job.cp   = acc;
                            job.ndig = num_digits(acc);
                        end
                    end
                end
            end else begin
                if (r_pend != 2'd0 && i_cfg.abort) begin
                    job.main = MN_ERR;
                    n_abt    = 1'b1;
                end else begin
                    job.pre     = (r_pend != 2'd0);
                    job.pre_dig = MK_LEAD_IN_SEQ;
                    n_pend      = 2'd0;
                    priority if (i_in_byte < 8'he0) begin
                        n_part = CP_W'(i_in_byte[4:0]);
                        n_pend = 2'd1;
                    end else if (i_in_byte < 8'hf0) begin
                        n_part = CP_W'(i_in_byte[3:0]);
                        n_pend = 2'd2;
                    end else if (i_in_byte < 8'hf8) begin
                        n_part = CP_W'(i_in_byte[2:0]);
                        n_pend = 2'd3;
                    end else if (i_cfg.abort) begin
                        job.main = MN_ERR;
                        n_abt    = 1'b1;
                    end else begin
                        job.main     = MN_MARK;
                        job.mark_dig = MK_BAD_LEAD;
                    end
                end
            end
        end
        // text end: open sequence, then the done item, then clear
        if (i_text_end) begin
            if (!n_abt && n_pend != 2'd0) begin
                if (i_cfg.abort) begin
                    job.end_err = 1'b1;
                    n_abt       = 1'b1;
                end else begin
                    job.end_mark = 1'b1;
                end
            end
            job.done     = 1'b1;
            job.done_err = n_abt;
            n_pend  = 2'd0;
            n_part  = '0;
            n_abt   = 1'b0;
            n_lim   = 1'b0;
            n_count = '0;
        end else begin
            sum     = {1'b0, r_count} + (COUNT_BITS + 1)'(job_bytes(job));
            n_count = (sum > {1'b0, CAP}) ? CAP : sum[COUNT_BITS-1:0];
        end
    end

    assign o_job  = job;
    assign o_push = accept && (job.pre || job.main != MN_NONE || job.end_mark ||
                               job.end_err || job.done);

    // decoder state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend  <= 2'd0;
            r_part  <= '0;
            r_count <= '0;
            r_abt   <= 1'b0;
            r_lim   <= 1'b0;
        end else if (accept) begin
            r_pend  <= n_pend;
            r_part  <= n_part;
            r_count <= n_count;
            r_abt   <= n_abt;
            r_lim   <= n_lim;
        end
    end

endmodule

// ----- rtl/core/u2c_queue.sv -----
module u2c_queue
    import u2c_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_job    i_job,
    input  logic    i_pop,
    output t_job    o_head,
    output t_q_stat o_stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_cnt;

    assign o_head       = r_mem[r_rd];
    assign o_stat.full  = (r_cnt == CNT_W'(DEPTH));
    assign o_stat.empty = (r_cnt == '0);

    // job storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == LAST) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == LAST) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// ----- rtl/core/u2c_back.sv -----
module u2c_back
    import u2c_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_job       i_head,
    input  t_q_stat    i_q_stat,
    input  logic       i_ready,
    output logic       o_pop,
    output logic       o_valid,
    output logic [7:0] o_out_byte,
    output logic       o_has_byte,
    output logic       o_error_abort,
    output logic       o_run_last,
    output logic       o_done_res
);

    logic            r_busy;
    t_job            r_job;
    t_seg            r_seg;
    logic [3:0]      r_idx;
    logic [CP_W-1:0] r_rem;
    logic [2:0]      r_pow;

    logic            slot_free, fire, load;
    logic            seg_last, nxt_found, job_last, is_digit;
    t_seg            nxt_seg, first_seg;
    logic [7:0]      it_byte;
    logic            it_has, it_err, it_done;
    logic [CP_W-1:0] pw;
    logic [3:0]      dig;
    logic [CP_W-1:0] sub;

    // next present segment after a given one
    function automatic logic [2:0] seg_after(input t_job j, input t_seg s);
        logic [2:0] r;
        r = 3'b000;
        if (s == SG_PRE && j.main != MN_NONE) begin
            r = {1'b1, SG_MAIN};
        end else if ((s == SG_PRE || s == SG_MAIN) && (j.end_mark || j.end_err)) begin
            r = {1'b1, SG_END};
        end else if (s != SG_DONE && j.done) begin
            r = {1'b1, SG_DONE};
        end
        return r;
    endfunction

    function automatic logic [7:0] mark_char(input logic [3:0] idx, input logic [2:0] d);
        return (idx == 4'd1) ? (CH_ZERO + {5'b0, d}) : CH_QMARK;
    endfunction

    assign slot_free = !o_valid || i_ready;
    assign fire      = r_busy && slot_free;

    // digit of the escape by compare against multiples of the power of ten
    assign pw = pow10(r_pow);
    always_comb begin
        dig = 4'd0;
        for (int d = 1; d <= 9; d++) begin
            if ({3'b000, r_rem} >= 24'(d) * {3'b000, pw}) begin
                dig = 4'(d);
            end
        end
    end
    assign sub = CP_W'({17'b0, dig} * pw);

    // item for the current segment and position
    always_comb begin
        it_byte  = 8'h00;
        it_has   = 1'b1;
        it_err   = 1'b0;
        it_done  = 1'b0;
        seg_last = 1'b0;
        is_digit = 1'b0;
        unique case (r_seg)
            SG_PRE: begin
                it_byte  = mark_char(r_idx, r_job.pre_dig);
                seg_last = (r_idx == 4'd2);
            end
            SG_MAIN: begin
                unique case (r_job.main)
                    MN_BYTE: begin
                        it_byte  = r_job.data;
                        seg_last = 1'b1;
                    end
                    MN_MARK: begin
                        it_byte  = mark_char(r_idx, r_job.mark_dig);
                        seg_last = (r_idx == 4'd2);
                    end
                    MN_ESC: begin
                        priority if (r_idx == 4'd0) begin
                            it_byte = CH_AMP;
                        end else if (r_idx == 4'd1) begin
                            it_byte = CH_HASH;
                        end else if (r_idx == {1'b0, r_job.ndig} + 4'd2) begin
                            it_byte  = CH_SEMI;
                            seg_last = 1'b1;
                        end else begin
                            it_byte  = CH_ZERO + {4'b0, dig};
                            is_digit = 1'b1;
                        end
                    end
                    default: begin
                        it_has   = 1'b0;
                        it_err   = 1'b1;
                        seg_last = 1'b1;
                    end
                endcase
            end
            SG_END: begin
                if (r_job.end_err) begin
                    it_has   = 1'b0;
                    it_err   = 1'b1;
                    seg_last = 1'b1;
                end else begin
                    it_byte  = mark_char(r_idx, MK_OPEN_AT_END);
                    seg_last = (r_idx == 4'd2);
                end
            end
            SG_DONE: begin
                it_has   = 1'b0;
                it_err   = r_job.done_err;
                it_done  = 1'b1;
                seg_last = 1'b1;
            end
            default: seg_last = 1'b1;
        endcase
    end

    assign {nxt_found, nxt_seg} = seg_after(r_job, r_seg);
    assign job_last  = seg_last && !nxt_found;
    assign load      = !i_q_stat.empty && (!r_busy || (fire && job_last));
    assign o_pop     = load;
    assign first_seg = i_head.pre ? SG_PRE : t_seg'(seg_after(i_head, SG_PRE));

    // sequencer registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (load) begin
            r_busy <= 1'b1;
        end else if (fire && job_last) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_job <= i_head;
            r_seg <= first_seg;
            r_idx <= 4'd0;
            r_rem <= i_head.cp;
            r_pow <= i_head.ndig - 3'd1;
        end else if (fire) begin
            if (seg_last) begin
                r_seg <= nxt_seg;
                r_idx <= 4'd0;
            end else begin
                r_idx <= r_idx + 4'd1;
            end
            if (is_digit) begin
                r_rem <= r_rem - sub;
                r_pow <= r_pow - 3'd1;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (slot_free) begin
            o_valid <= fire;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            o_out_byte    <= it_byte;
            o_has_byte    <= it_has;
            o_error_abort <= it_err;
            o_run_last    <= job_last;
            o_done_res    <= it_done;
        end
    end

endmodule

// ----- tb/tb_utf8_to_cp1251_transcoder.sv -----
module tb_utf8_to_cp1251_transcoder;
    import u2c_pkg::*;

    typedef struct {
        logic [7:0] out_byte;
        logic       has_byte;
        logic       error_abort;
        logic       run_last;
        logic       done_res;
    } t_res;

    // expected output store and the transcoding predictor
    class cp1251_scoreboard;
        t_res        pending_q[$];
        logic [23:0] max_len;
        logic        abort_mode;
        logic [1:0]  need_cont;
        logic [20:0] code_acc;
        logic [23:0] out_cnt;
        logic        was_aborted;
        logic        limit_hit;
        int          err_cnt;

        function void clear_text();
            need_cont   = 0;
            code_acc    = 0;
            out_cnt     = 0;
            was_aborted = 0;
            limit_hit   = 0;
        endfunction

        function new();
            max_len    = 0;
            abort_mode = 0;
            err_cnt    = 0;
            clear_text();
        endfunction

        function void push(logic [7:0] b, logic h, logic e, logic d);
            t_res r;
            r.out_byte = b; r.has_byte = h; r.error_abort = e;
            r.run_last = 0; r.done_res = d;
            pending_q.insert(pending_q.size(), r);
            if (h && out_cnt != 24'hffffff) out_cnt++;
        endfunction

        function void emit(logic [7:0] b);
            push(b, 1, 0, 0);
        endfunction

        // returns 1 when the text got aborted
        function bit malformed(int dig);
            if (abort_mode) begin
                push(0, 0, 1, 0);
                was_aborted = 1;
                return 1;
            end
            emit(CH_QMARK); emit(CH_ZERO + dig[7:0]); emit(CH_QMARK);
            return 0;
        endfunction

        function logic [7:0] lookup(logic [20:0] cp);
            logic [7:0] lo;
            lo = cp[7:0];
            case (cp[20:8])
                13'h000:
                    if (lo inside {8'ha0, 8'ha4, 8'ha6, 8'ha7, 8'ha9, 8'hab, 8'hac,
                                   8'had, 8'hae, 8'hb0, 8'hb1, 8'hb5, 8'hb6,
                                   8'hb7, 8'hbb}) return lo;
                13'h004: begin
                    if (lo < 8'h10) return PAGE04_LO[lo[3:0]];
                    if (lo < 8'h50) return 8'hc0 + (lo - 8'h10);
                    if (lo < 8'h60) return PAGE04_HI[lo[3:0]];
                    if (lo == 8'h90) return 8'ha5;
                    if (lo == 8'h91) return 8'hb4;
                end
                13'h020: begin
                    if (lo < 8'h40) return PAGE20_LO[lo[5:0]];
                    if (lo == 8'hac) return 8'h88;
                end
                13'h021: begin
                    if (lo == 8'h16) return 8'hb9;
                    if (lo == 8'h22) return 8'h99;
                end
                13'h0ff: if (lo == 8'hfd) return 8'h20;
                default: ;
            endcase
            return 0;
        endfunction

        function void emit_code(logic [20:0] cp);
            logic [7:0] m;
            int digs[$];
            int v;
            m = lookup(cp);
            if (m != 0) begin
                emit(m);
                return;
            end
            emit(CH_AMP); emit(CH_HASH);
            v = cp;
            do begin
                digs.push_front(v % 10);
                v = v / 10;
            end while (v != 0);
            foreach (digs[k]) emit(CH_ZERO + digs[k][7:0]);
            emit(CH_SEMI);
        endfunction

        function void decode(logic [7:0] c);
            logic [7:0] l;
            if (c < 8'h80) begin
                if (need_cont != 0 && malformed(1)) return;
                emit(c);
                need_cont = 0;
            end else if (c[7:6] == 2'b10) begin
                if (need_cont == 0) begin
                    void'(malformed(2));
                    return;
                end
                code_acc = {code_acc[14:0], c[5:0]};
                need_cont--;
                if (need_cont == 0) begin
                    if (code_acc < 21'h80) void'(malformed(3));
                    else emit_code(code_acc);
                end
            end else begin
                if (need_cont != 0 && malformed(4)) return;
                l = c - 8'hc0;
                need_cont = 0;
                if (l < 32) begin code_acc = l; need_cont = 1; end
                else if (l < 48) begin code_acc = l - 32; need_cont = 2; end
                else if (l < 56) begin code_acc = l - 48; need_cont = 3; end
                else void'(malformed(5));
            end
        endfunction

        // note one accepted input byte
        function void note_input(logic [7:0] c, logic last);
            int first;
            first = pending_q.size();
            if (!was_aborted && !limit_hit) begin
                if (max_len != 0 && out_cnt >= max_len) limit_hit = 1;
                else decode(c);
            end
            if (last) begin
                if (!was_aborted && need_cont != 0) void'(malformed(6));
                push(0, 0, was_aborted, 1);
                clear_text();
            end
            if (pending_q.size() > first) pending_q[$].run_last = 1;
        endfunction

        function void report(string what);
            $display("mismatch: %s", what);
            err_cnt++;
        endfunction

        function void check(t_res got);
            t_res w;
            if (pending_q.size() == 0) begin
                report($sformatf("unexpected item byte=%h", got.out_byte));
                return;
            end
            w = pending_q.pop_front();
            if (got.out_byte != w.out_byte)
                report($sformatf("out_byte %h want %h", got.out_byte, w.out_byte));
            if (got.has_byte != w.has_byte) report("has_byte");
            if (got.error_abort != w.error_abort) report("error_abort");
            if (got.run_last != w.run_last) report("run_last");
            if (got.done_res != w.done_res) report("done_res");
        endfunction
    endclass

    logic             i_clk = 0;
    logic             i_rst_n = 0;
    logic             i_valid = 0;
    logic             o_ready;
    logic [7:0]       i_in_byte = 0;
    logic             i_text_end = 0;
    logic             o_valid;
    logic             i_ready = 0;
    logic [7:0]       o_out_byte;
    logic             o_has_byte;
    logic             o_error_abort;
    logic             o_run_last;
    logic             o_done_res;
    logic             i_cfg_we = 0;
    logic             i_cfg_idx = 0;
    logic [LEN_W-1:0] i_cfg_data = 0;

    cp1251_scoreboard sb;
    int  idle_cycles = 0;
    bit  hold_sink = 0;
    bit  stim_done = 0;
    int  n_items = 0;

    utf8_to_cp1251_transcoder u_dut (.*);

    always #5 i_clk = ~i_clk;

    // watchdog on cycles with no handshake
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 3000) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // accepted inputs and results at the rising edge
    always @(posedge i_clk) begin
        t_res r;
        if (i_rst_n && i_valid && o_ready) sb.note_input(i_in_byte, i_text_end);
        if (i_rst_n && o_valid && i_ready) begin
            r.out_byte = o_out_byte; r.has_byte = o_has_byte;
            r.error_abort = o_error_abort; r.run_last = o_run_last;
            r.done_res = o_done_res;
            sb.check(r);
        end
    end

    // receiver with random stalls
    initial begin
        int w;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_sink) i_ready <= 0;
            else begin
                w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
                if (w == 0 || $urandom_range(0, 1)) i_ready <= 1;
                else begin
                    i_ready <= 0;
                    repeat (w) @(negedge i_clk);
                    i_ready <= 1;
                end
            end
        end
    end

    // offers one byte and returns at the falling edge after its acceptance
    task automatic send_byte(logic [7:0] b, logic last, bit gaps);
        int w;
        w = gaps ? $urandom_range(0, 13) : 0;
        if (gaps && $urandom_range(0, 2) == 0) w = 0;
        if (w > 0) begin
            i_valid <= 0;
            repeat (w) @(negedge i_clk);
        end
        i_valid    <= 1;
        i_in_byte  <= b;
        i_text_end <= last;
        while (!o_ready) @(negedge i_clk);
        @(posedge i_clk);
        @(negedge i_clk);
        n_items++;
    endtask

    task automatic drain();
        i_valid <= 0;
        while (sb.pending_q.size() != 0) @(negedge i_clk);
        repeat (30) @(negedge i_clk);
    endtask

    task automatic write_cfg(logic idx, logic [LEN_W-1:0] val);
        i_cfg_we <= 1; i_cfg_idx <= idx; i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 0;
        if (idx == CFG_MAX_LEN) sb.max_len = val;
        else sb.abort_mode = val[0];
        @(negedge i_clk);
    endtask

    // one random utf-8 continuation byte
    function automatic logic [7:0] rand_cont();
        return 8'h80 | 8'($urandom_range(0, 63));
    endfunction

    task automatic send_char(bit gaps);
        int k;
        logic [20:0] cp;
        k = $urandom_range(0, 9);
        case (k)
            0, 1: send_byte(8'($urandom_range(0, 127)), 0, gaps);
            2, 3, 4: begin
                cp = (k == 2) ? 21'h400 + $urandom_range(0, 255)
                              : 21'h80 + $urandom_range(0, 1919);
                send_byte(8'hc0 | cp[10:6], 0, gaps);
                send_byte(8'h80 | cp[5:0], 0, gaps);
            end
            5, 6: begin
                cp = (k == 5) ? 21'h2000 + $urandom_range(0, 511)
                              : 21'($urandom_range(0, 65535));
                send_byte(8'he0 | cp[15:12], 0, gaps);
                send_byte(8'h80 | cp[11:6], 0, gaps);
                send_byte(8'h80 | cp[5:0], 0, gaps);
            end
            7: begin
                send_byte(8'hf0 | 8'($urandom_range(0, 7)), 0, gaps);
                send_byte(rand_cont(), 0, gaps);
                send_byte(rand_cont(), 0, gaps);
                send_byte(rand_cont(), 0, gaps);
            end
            default: send_byte(8'($urandom), 0, gaps);
        endcase
    endtask

    task automatic random_text(int len, bit gaps);
        repeat (len) send_char(gaps);
        send_byte(($urandom_range(0, 3) == 0) ? 8'hc3 : 8'($urandom), 1, gaps);
    endtask

    initial begin
        sb = new();
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);

        // directed: mapped, an escape, every marker
        send_byte(8'h00, 0, 0); send_byte(8'h7f, 0, 0);
        send_byte(8'hd0, 0, 0); send_byte(8'h90, 0, 0);
        send_byte(8'he2, 0, 0); send_byte(8'h82, 0, 0); send_byte(8'hac, 0, 0);
        send_byte(8'hf4, 0, 0); send_byte(8'h8f, 0, 0); send_byte(8'hbf, 0, 0);
        send_byte(8'hbf, 0, 0);
        send_byte(8'hc3, 0, 0); send_byte(8'h41, 0, 0);
        send_byte(8'h80, 0, 0);
        send_byte(8'hc1, 0, 0); send_byte(8'hbf, 0, 0);
        send_byte(8'he0, 0, 0); send_byte(8'hd1, 0, 0); send_byte(8'h8f, 0, 0);
        send_byte(8'hf8, 0, 0); send_byte(8'hff, 0, 0);
        send_byte(8'hf0, 1, 0);
        drain();

        // abort mode with the smallest limit
        write_cfg(CFG_ABORT, 1);
        write_cfg(CFG_MAX_LEN, 1);
        send_byte(8'h41, 0, 0); send_byte(8'h42, 0, 0); send_byte(8'hc3, 1, 0);
        drain();
        write_cfg(CFG_MAX_LEN, 0);
        send_byte(8'h80, 0, 0); send_byte(8'h41, 1, 0);
        drain();

        // long receiver hold while the sender keeps offering
        hold_sink = 1;
        fork
            begin repeat (200) @(negedge i_clk); hold_sink = 0; end
            begin random_text(12, 0); drain(); end
        join
        drain();

        // random phases over several register settings
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin write_cfg(CFG_ABORT, 0); write_cfg(CFG_MAX_LEN, 0); end
                1: write_cfg(CFG_MAX_LEN, 24'hffffff);
                2: write_cfg(CFG_MAX_LEN, 7);
                3: begin write_cfg(CFG_ABORT, 1); write_cfg(CFG_MAX_LEN, 0); end
                4: write_cfg(CFG_MAX_LEN, $urandom_range(1, 20));
                default: begin write_cfg(CFG_ABORT, 0); write_cfg(CFG_MAX_LEN, 0); end
            endcase
            repeat (4) random_text($urandom_range(1, 7), ph != 1);
            drain();
        end
        stim_done = 1;
        if (sb.err_cnt == 0 && sb.pending_q.size() == 0) $display("TEST PASSED");
        else $display("TEST FAILED");
        $finish;
    end
endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/u2c_pkg.sv
rtl/core/u2c_front.sv
rtl/core/u2c_queue.sv
rtl/core/u2c_back.sv
rtl/core/utf8_to_cp1251_transcoder.sv
tb/tb_utf8_to_cp1251_transcoder.sv
